### src/armf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP reply MAC filter package
// Shared constants, command codes and the queue entry type of the filter.
// ----------------------------------------------------------------------------
package armf_pkg;

    localparam int FILTER_ENTRIES = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 3;
    localparam int INDEX_W = 3;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] MIN_FRAME_BYTES = 6'd42;
    localparam logic [COUNT_W-1:0] SRC_MAC_FIRST   = 6'd6;
    localparam logic [COUNT_W-1:0] SRC_MAC_LAST    = 6'd11;
    localparam logic [COUNT_W-1:0] ETYPE_FIRST     = 6'd12;
    localparam logic [COUNT_W-1:0] ETYPE_LAST      = 6'd13;
    localparam logic [COUNT_W-1:0] OPCODE_FIRST    = 6'd20;
    localparam logic [COUNT_W-1:0] OPCODE_LAST     = 6'd21;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;

    typedef enum logic [1:0] {
        CMD_FRAME_BYTE       = 2'd0,
        CMD_WRITE_ENTRY      = 2'd1,
        CMD_INVALIDATE_ENTRY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_WRITE      = 2'd0,
        OP_INVALIDATE = 2'd1,
        OP_VERDICT    = 2'd2
    } op_kind_t;

    // One unit of work for the back end: a table update or a frame verdict.
    typedef struct packed {
        op_kind_t            kind;
        logic [INDEX_W-1:0]  index;
        logic [MAC_W-1:0]    mac;
        logic                seen;
    } q_entry_t;

endpackage

### src/armf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP reply MAC filter front end
// Parses frame bytes, captures header fields and queues table ops and verdicts.
// ----------------------------------------------------------------------------
module armf_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_accept,
    input  logic [1:0]                   in_cmd,
    input  logic [7:0]                   in_data_byte,
    input  logic                         in_last_byte,
    input  logic [armf_pkg::INDEX_W-1:0] in_entry_index,
    input  logic [armf_pkg::MAC_W-1:0]   in_entry_mac,
    output logic                         push_valid,
    output armf_pkg::q_entry_t           push_entry
);

    logic [armf_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [armf_pkg::MAC_W-1:0]   source_mac_reg, source_mac_next;
    logic [15:0]                  ether_type_reg, ether_type_next;
    logic [15:0]                  arp_opcode_reg, arp_opcode_next;

    // Header values including the byte being accepted now.
    logic [armf_pkg::COUNT_W-1:0] count_upd;
    logic [armf_pkg::MAC_W-1:0]   mac_upd;
    logic [15:0]                  etype_upd;
    logic [15:0]                  opcode_upd;
    logic                         seen_upd;

    always_comb begin
        count_upd  = byte_count_reg;
        mac_upd    = source_mac_reg;
        etype_upd  = ether_type_reg;
        opcode_upd = arp_opcode_reg;
        if (byte_count_reg >= armf_pkg::SRC_MAC_FIRST &&
            byte_count_reg <= armf_pkg::SRC_MAC_LAST) begin
            mac_upd = {source_mac_reg[armf_pkg::MAC_W-9:0], in_data_byte};
        end else if (byte_count_reg == armf_pkg::ETYPE_FIRST ||
                     byte_count_reg == armf_pkg::ETYPE_LAST) begin
            etype_upd = {ether_type_reg[7:0], in_data_byte};
        end else if (byte_count_reg == armf_pkg::OPCODE_FIRST ||
                     byte_count_reg == armf_pkg::OPCODE_LAST) begin
            opcode_upd = {arp_opcode_reg[7:0], in_data_byte};
        end
        if (byte_count_reg < armf_pkg::MIN_FRAME_BYTES) begin
            count_upd = byte_count_reg + 6'd1;
        end
        seen_upd = (count_upd >= armf_pkg::MIN_FRAME_BYTES) &&
                   (etype_upd == armf_pkg::ETHERTYPE_ARP) &&
                   (opcode_upd == armf_pkg::ARP_OP_REPLY);
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        source_mac_next  = source_mac_reg;
        ether_type_next  = ether_type_reg;
        arp_opcode_next  = arp_opcode_reg;
        push_valid       = 1'b0;
        push_entry.kind  = armf_pkg::OP_VERDICT;
        push_entry.index = in_entry_index;
        push_entry.mac   = in_entry_mac;
        push_entry.seen  = seen_upd;
        if (in_accept) begin
            case (armf_pkg::cmd_t'(in_cmd))
                armf_pkg::CMD_FRAME_BYTE: begin
                    if (in_last_byte) begin
                        // Verdict goes out; the parser starts over.
                        push_valid      = 1'b1;
                        push_entry.mac  = mac_upd;
                        byte_count_next = '0;
                        source_mac_next = '0;
                        ether_type_next = '0;
                        arp_opcode_next = '0;
                    end else begin
                        byte_count_next = count_upd;
                        source_mac_next = mac_upd;
                        ether_type_next = etype_upd;
                        arp_opcode_next = opcode_upd;
                    end
                end
                armf_pkg::CMD_WRITE_ENTRY: begin
                    push_valid      = 1'b1;
                    push_entry.kind = armf_pkg::OP_WRITE;
                end
                armf_pkg::CMD_INVALIDATE_ENTRY: begin
                    push_valid      = 1'b1;
                    push_entry.kind = armf_pkg::OP_INVALIDATE;
                end
                default: begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            source_mac_reg <= '0;
            ether_type_reg <= '0;
            arp_opcode_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            source_mac_reg <= source_mac_next;
            ether_type_reg <= ether_type_next;
            arp_opcode_reg <= arp_opcode_next;
        end
    end

endmodule

### src/armf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP reply MAC filter work queue
// Short register FIFO that decouples the parser from the table back end.
// ----------------------------------------------------------------------------
module armf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  armf_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output armf_pkg::q_entry_t head_entry
);

    armf_pkg::q_entry_t            slots_reg [armf_pkg::QUEUE_DEPTH];
    logic [armf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [armf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [armf_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == armf_pkg::QCNT_W'(armf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == armf_pkg::QPTR_W'(armf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == armf_pkg::QPTR_W'(armf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/armf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP reply MAC filter back end
// Holds the filter table, applies updates and registers frame verdicts.
// ----------------------------------------------------------------------------
module armf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        head_valid,
    input  armf_pkg::q_entry_t          head_entry,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_drop,
    output logic                        out_seen,
    output logic [armf_pkg::SLOT_W-1:0] out_slot
);

    logic [armf_pkg::MAC_W-1:0]        filter_mac_reg [armf_pkg::FILTER_ENTRIES];
    logic [armf_pkg::FILTER_ENTRIES-1:0] filter_valid_reg, filter_valid_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        drop_reg;
    logic                        seen_reg;
    logic [armf_pkg::SLOT_W-1:0] slot_reg;

    logic                        is_verdict;
    logic                        out_free;
    logic                        hit;
    logic [armf_pkg::SLOT_W-1:0] hit_slot;

    assign is_verdict = (head_entry.kind == armf_pkg::OP_VERDICT);
    assign out_free   = !out_valid_reg || out_ready;
    // Table updates never wait on the output side.
    assign pop        = head_valid && (!is_verdict || out_free);

    // Parallel compare; scanning from the top leaves the lowest hit.
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = armf_pkg::FILTER_ENTRIES - 1; i >= 0; i--) begin
            if (filter_valid_reg[i] && filter_mac_reg[i] == head_entry.mac) begin
                hit      = 1'b1;
                hit_slot = armf_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        filter_valid_next = filter_valid_reg;
        for (int i = 0; i < armf_pkg::FILTER_ENTRIES; i++) begin
            if (pop && int'(head_entry.index) == i) begin
                if (head_entry.kind == armf_pkg::OP_WRITE) begin
                    filter_valid_next[i] = 1'b1;
                end else if (head_entry.kind == armf_pkg::OP_INVALIDATE) begin
                    filter_valid_next[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop && is_verdict) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_valid_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            filter_valid_reg <= filter_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < armf_pkg::FILTER_ENTRIES; i++) begin
            if (pop && head_entry.kind == armf_pkg::OP_WRITE &&
                int'(head_entry.index) == i) begin
                filter_mac_reg[i] <= head_entry.mac;
            end
        end
        if (pop && is_verdict) begin
            drop_reg <= head_entry.seen && hit;
            seen_reg <= head_entry.seen;
            slot_reg <= (head_entry.seen && hit) ? hit_slot : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_drop  = drop_reg;
    assign out_seen  = seen_reg;
    assign out_slot  = slot_reg;

endmodule

### src/arp_reply_mac_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP reply MAC filter
// Drops ARP replies whose source MAC matches a valid filter table entry.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one item per handshake. With s_tuser set to the
// frame-byte command, s_tdata[7:0] is one Ethernet byte in wire order and
// s_tlast marks the final byte of the frame. The write and invalidate
// commands use s_tdata[10:8] as the table slot and s_tdata[58:11] as the MAC.
// The master stream returns one verdict item per frame, nothing for table
// commands or for the unused command code.
// Throughput is one item per cycle while s_tready is high; the parser then takes
// a byte every cycle and the back end compares all table slots in parallel.
// A verdict is written into the queue by the edge that accepts the last byte,
// then into the output register once it is free, where m_tvalid rises; it is
// taken when the receiver holds m_tready high.
// A two-entry queue sits between the parser and the table; while the receiver
// holds m_tready low, table updates still drain until a verdict reaches the
// queue head, and s_tready drops only when the queue fills behind a waiting verdict.
// Reset clears the parser state, the queue, the output valid flag and all table
// valid bits; table MACs are undefined until written.
// ----------------------------------------------------------------------------
module arp_reply_mac_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: data_byte [7:0], entry_index [10:8], entry_mac [58:11], zeros above
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    // s_tuser: cmd [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: drop [0], arp_reply_seen [1], matched_slot [4:2], zeros above
    output logic [7:0]  m_tdata
);

    logic                        in_accept;
    logic                        push_valid;
    armf_pkg::q_entry_t          push_entry;
    logic                        q_full;
    logic                        q_pop;
    logic                        head_valid;
    armf_pkg::q_entry_t          head_entry;
    logic                        out_drop;
    logic                        out_seen;
    logic [armf_pkg::SLOT_W-1:0] out_slot;

    // Every accepted item pushes at most one queue entry, so a free slot is
    // all the front end needs.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    armf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (in_accept),
        .in_cmd         (s_tuser),
        .in_data_byte   (s_tdata[7:0]),
        .in_last_byte   (s_tlast),
        .in_entry_index (s_tdata[10:8]),
        .in_entry_mac   (s_tdata[58:11]),
        .push_valid     (push_valid),
        .push_entry     (push_entry)
    );

    armf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    armf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_drop   (out_drop),
        .out_seen   (out_seen),
        .out_slot   (out_slot)
    );

    assign m_tdata = {3'b000, out_slot, out_seen, out_drop};

endmodule
